// File: design/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types, codes and constants of the mark-and-sweep slot pool.
// ----------------------------------------------------------------------------
package msp_pkg;

  localparam int SLOTS_DEF  = 1024;
  localparam int BYTES_W    = 13;
  localparam int ADDR_W     = 32;
  localparam int FREED_W    = 11;
  localparam int PADDR_W    = 4;

  localparam logic [BYTES_W-1:0] BYTES_MAX   = 13'd4096;
  localparam logic [BYTES_W-1:0] BYTES_RESET = 13'd16;
  localparam logic [10:0]        SLOTS_RESET = 11'd1024;

  typedef enum logic [2:0] {
    ACT_ALLOC    = 3'd0,
    ACT_DISCARD  = 3'd1,
    ACT_MARK     = 3'd2,
    ACT_POP_GRAY = 3'd3,
    ACT_SWEEP    = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_OUT   = 2'd2,
    ST_WRONG = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_POOL_BASE    = 2'd0,
    REG_SLOT_BYTES   = 2'd1,
    REG_SLOTS_IN_USE = 2'd2,
    REG_GRAY_ENABLE  = 2'd3
  } reg_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_FIN,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_EXEC,
    B_STACK,
    B_BREAD,
    B_BWAIT,
    B_SWEEP,
    B_RES
  } back_state_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [ADDR_W-1:0]  address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  result_address;
    logic [FREED_W-1:0] freed_count;
    logic [1:0]         status;
  } out_item_t;

  // effective configuration
  typedef struct packed {
    logic [ADDR_W-1:0]  pool_base;
    logic [BYTES_W-1:0] slot_bytes;
    logic               gray_enable;
  } cfg_t;

  // classified item, front to back
  typedef struct packed {
    logic [2:0]        action;
    logic              hit;
    logic              aligned;
    logic [ADDR_W-1:0] base;
  } cmd_t;

endpackage

// File: design/mark_sweep_slot_pool.sv
// ----------------------------------------------------------------------------
// mark_sweep_slot_pool
// Slot pool for a mark-and-sweep collector: allocate, discard, mark,
// pop gray and sweep over allocated/reachable bitmaps and two slot stacks.
//
//   channel | direction | handshake                     | beat
//   cfg     | in        | psel/penable/pwrite, pready=1 | one register, 32 bits
//   in      | in        | in_valid / in_ready           | in_item_t
//   out     | out       | out_valid / out_ready         | out_item_t
//
// Discard and mark pass the restoring divider in the front; the other actions
// go straight to the queue. The executor's steps per item are set by the
// registered reads of the stack and bitmap memories; a sweep walks the
// effective slot count. After reset or a slots_in_use write, a clearing pass
// over all SLOTS bitmap entries blocks input.
// A stalled output holds the executor; the front goes on until the two-entry queue fills.
// ----------------------------------------------------------------------------
module mark_sweep_slot_pool #(
  parameter int SLOTS = msp_pkg::SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [msp_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  msp_pkg::in_item_t           in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output msp_pkg::out_item_t          out_item
);

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int QW = $bits(msp_pkg::cmd_t) + SW;

  logic [31:0]                   pool_base;
  logic [msp_pkg::BYTES_W-1:0]   slot_bytes;
  logic [10:0]                   slots_in_use;
  logic                          gray_enable;
  logic                          wr;
  logic                          restart;
  msp_pkg::reg_t                 ridx;
  msp_pkg::cfg_t                 cfg;
  logic [CW-1:0]                 n;
  logic                          clearing;
  logic                          fq_valid;
  logic                          fq_ready;
  msp_pkg::cmd_t                 f_cmd;
  logic [SW-1:0]                 f_slot;
  logic                          bq_valid;
  logic                          bq_ready;
  logic [QW-1:0]                 bq_data;

  assign pready  = 1'b1;
  assign ridx    = msp_pkg::reg_t'(paddr[3:2]);
  assign wr      = psel && penable && pwrite;
  assign restart = wr && (ridx == msp_pkg::REG_SLOTS_IN_USE);

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base    <= '0;
      slot_bytes   <= msp_pkg::BYTES_RESET;
      slots_in_use <= msp_pkg::SLOTS_RESET;
      gray_enable  <= 1'b1;
    end else if (wr) begin
      case (ridx)
        msp_pkg::REG_POOL_BASE:    pool_base    <= pwdata;
        msp_pkg::REG_SLOT_BYTES:   slot_bytes   <= pwdata[msp_pkg::BYTES_W-1:0];
        msp_pkg::REG_SLOTS_IN_USE: slots_in_use <= pwdata[10:0];
        msp_pkg::REG_GRAY_ENABLE:  gray_enable  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      msp_pkg::REG_POOL_BASE:    prdata = pool_base;
      msp_pkg::REG_SLOT_BYTES:   prdata = 32'(slot_bytes);
      msp_pkg::REG_SLOTS_IN_USE: prdata = 32'(slots_in_use);
      msp_pkg::REG_GRAY_ENABLE:  prdata = 32'(gray_enable);
      default:                   prdata = '0;
    endcase
  end

  always_comb begin
    cfg.pool_base   = pool_base;
    cfg.gray_enable = gray_enable;
    if (slot_bytes == '0) begin
      cfg.slot_bytes = msp_pkg::BYTES_W'(1);
    end else if (slot_bytes > msp_pkg::BYTES_MAX) begin
      cfg.slot_bytes = msp_pkg::BYTES_MAX;
    end else begin
      cfg.slot_bytes = slot_bytes;
    end
    if (slots_in_use == '0) begin
      n = CW'(1);
    end else if (32'(slots_in_use) > 32'(SLOTS)) begin
      n = CW'(SLOTS);
    end else begin
      n = CW'(slots_in_use);
    end
  end

  msp_front #(.SLOTS(SLOTS)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .clearing(clearing), .cfg(cfg), .n(n),
    .q_valid(fq_valid), .q_ready(fq_ready), .q_cmd(f_cmd), .q_slot(f_slot)
  );

  msp_queue #(.WIDTH(QW)) u_queue (
    .clk(clk), .rst(rst),
    .in_valid(fq_valid), .in_ready(fq_ready), .in_data({f_cmd, f_slot}),
    .out_valid(bq_valid), .out_ready(bq_ready), .out_data(bq_data)
  );

  msp_back #(.SLOTS(SLOTS)) u_back (
    .clk(clk), .rst(rst), .restart(restart), .cfg(cfg), .n(n),
    .q_valid(bq_valid), .q_ready(bq_ready),
    .q_cmd(msp_pkg::cmd_t'(bq_data[QW-1:SW])), .q_slot(bq_data[SW-1:0]),
    .clearing(clearing),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && clearing))
    else $error("item accepted during clearing pass");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    restart |=> clearing)
    else $error("slot count write did not start clearing pass");

  a_out_zero_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == msp_pkg::ST_OUT |-> out_item.result_address == '0)
    else $error("out-of-pool result carries an address");

  a_freed_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.freed_count != '0 |-> out_item.status == msp_pkg::ST_OK)
    else $error("freed slots reported with error status");

endmodule

// File: design/msp_ram.sv
// ----------------------------------------------------------------------------
// msp_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module msp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/msp_queue.sv
// ----------------------------------------------------------------------------
// msp_queue
// Two-entry queue between the classifier and the executor.
// ----------------------------------------------------------------------------
module msp_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic [1:0]       cnt;
  logic [WIDTH-1:0] d0;
  logic [WIDTH-1:0] d1;
  logic             push;
  logic             pop;

  assign in_ready  = (cnt != 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign out_data  = d0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
    if (pop) begin
      d0 <= (cnt == 2'd2) ? d1 : in_data;
    end else if (push && cnt == 2'd0) begin
      d0 <= in_data;
    end
    if (push && !pop && cnt == 2'd1) begin
      d1 <= in_data;
    end
  end

endmodule

// File: design/msp_front.sv
// ----------------------------------------------------------------------------
// msp_front
// Accepts items, resolves discard/mark addresses to a slot with a
// bit-per-cycle restoring divider, and queues the classified item.
// ----------------------------------------------------------------------------
module msp_front #(
  parameter int SLOTS = msp_pkg::SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  msp_pkg::in_item_t          in_item,
  input  logic                       clearing,
  input  msp_pkg::cfg_t              cfg,
  input  logic [$clog2(SLOTS+1)-1:0] n,
  output logic                       q_valid,
  input  logic                       q_ready,
  output msp_pkg::cmd_t              q_cmd,
  output logic [$clog2(SLOTS)-1:0]   q_slot
);

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int LW = (32 > msp_pkg::BYTES_W + SW) ? 32 : msp_pkg::BYTES_W + SW;
  localparam int KW = $clog2(SW + 1);

  msp_pkg::front_state_t state, state_next;

  logic [2:0]    act;
  logic [31:0]   addr;
  logic [LW-1:0] r;
  logic [LW-1:0] d;
  logic [SW-1:0] q;
  logic          ovf;
  logic [KW-1:0] k;
  msp_pkg::cmd_t cmd;
  logic [SW-1:0] slot;
  logic          accept;
  logic          locating;
  logic          ge;

  assign in_ready = (state == msp_pkg::F_IDLE) && !clearing;
  assign accept   = in_valid && in_ready;
  assign locating = (in_item.action == msp_pkg::ACT_DISCARD) ||
                    (in_item.action == msp_pkg::ACT_MARK);
  assign ge       = (r >= d);
  assign q_valid  = (state == msp_pkg::F_PUSH);
  assign q_cmd    = cmd;
  assign q_slot   = slot;

  always_comb begin
    state_next = state;
    case (state)
      msp_pkg::F_IDLE: begin
        if (accept) begin
          state_next = locating ? msp_pkg::F_DIV : msp_pkg::F_PUSH;
        end
      end
      msp_pkg::F_DIV: begin
        if (k == '0) begin
          state_next = msp_pkg::F_FIN;
        end
      end
      msp_pkg::F_FIN:  state_next = msp_pkg::F_PUSH;
      msp_pkg::F_PUSH: begin
        if (q_ready) begin
          state_next = msp_pkg::F_IDLE;
        end
      end
      default: state_next = msp_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msp_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      msp_pkg::F_IDLE: begin
        if (accept) begin
          act         <= in_item.action;
          addr        <= in_item.address;
          r           <= LW'(in_item.address - cfg.pool_base);
          d           <= LW'(cfg.slot_bytes) << SW;
          q           <= '0;
          ovf         <= 1'b0;
          k           <= KW'(SW);
          cmd.action  <= in_item.action;
          cmd.hit     <= 1'b0;
          cmd.aligned <= 1'b0;
          cmd.base    <= '0;
          slot        <= '0;
        end
      end
      msp_pkg::F_DIV: begin
        if (k == KW'(SW)) begin
          ovf <= ge;
        end else begin
          q <= {q[SW-2:0], ge};
          if (ge) begin
            r <= r - d;
          end
        end
        d <= d >> 1;
        k <= k - 1'b1;
      end
      msp_pkg::F_FIN: begin
        cmd.action  <= act;
        cmd.hit     <= !ovf && (CW'(q) < n);
        cmd.aligned <= (r == '0);
        cmd.base    <= addr - r[31:0];
        slot        <= q;
      end
      default: ;
    endcase
  end

endmodule

// File: design/msp_back.sv
// ----------------------------------------------------------------------------
// msp_back
// Executes classified items against the bitmap, free stack and gray stack
// memories, walks the bitmaps for a sweep and holds the result register.
// ----------------------------------------------------------------------------
module msp_back #(
  parameter int SLOTS = msp_pkg::SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       restart,
  input  msp_pkg::cfg_t              cfg,
  input  logic [$clog2(SLOTS+1)-1:0] n,
  input  logic                       q_valid,
  output logic                       q_ready,
  input  msp_pkg::cmd_t              q_cmd,
  input  logic [$clog2(SLOTS)-1:0]   q_slot,
  output logic                       clearing,
  output logic                       out_valid,
  input  logic                       out_ready,
  output msp_pkg::out_item_t         out_item
);

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int PW = SW + msp_pkg::BYTES_W;

  msp_pkg::back_state_t state, state_next;

  msp_pkg::cmd_t      cmd, cmd_next;
  logic [SW-1:0]      slot, slot_next;
  logic [CW-1:0]      fc, fc_next;
  logic [CW-1:0]      m, m_next;
  logic [CW-1:0]      gc, gc_next;
  logic [PW-1:0]      prod, prod_next;
  logic [31:0]        res_addr, res_addr_next;
  logic [CW-1:0]      res_freed, res_freed_next;
  msp_pkg::status_t   res_status, res_status_next;
  logic [SW-1:0]      clr, clr_next;
  logic [CW-1:0]      sr, sr_next;
  logic               pv, pv_next;
  logic [SW-1:0]      pidx, pidx_next;
  logic               out_valid_next;
  msp_pkg::out_item_t out_item_next;

  logic          bit_we;
  logic [SW-1:0] bit_waddr;
  logic [1:0]    bit_wdata;
  logic [SW-1:0] bit_raddr;
  logic [1:0]    bit_rdata;
  logic          free_we;
  logic [SW-1:0] free_waddr;
  logic [SW-1:0] free_raddr;
  logic [SW-1:0] free_rdata;
  logic [SW-1:0] free_wdata_sel;
  logic          gray_we;
  logic [SW-1:0] gray_waddr;
  logic [SW-1:0] gray_raddr;
  logic [SW-1:0] gray_rdata;
  logic          a;
  logic          rc;

  // bit 1 allocated, bit 0 reachable
  msp_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_bits (
    .clk(clk), .we(bit_we), .waddr(bit_waddr), .wdata(bit_wdata),
    .raddr(bit_raddr), .rdata(bit_rdata)
  );

  msp_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_free (
    .clk(clk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata_sel),
    .raddr(free_raddr), .rdata(free_rdata)
  );

  msp_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_gray (
    .clk(clk), .we(gray_we), .waddr(gray_waddr), .wdata(slot),
    .raddr(gray_raddr), .rdata(gray_rdata)
  );

  assign a        = bit_rdata[1];
  assign rc       = bit_rdata[0];
  assign clearing = (state == msp_pkg::B_CLEAR);

  always_comb begin
    state_next      = state;
    cmd_next        = cmd;
    slot_next       = slot;
    fc_next         = fc;
    m_next          = m;
    gc_next         = gc;
    prod_next       = prod;
    res_addr_next   = res_addr;
    res_freed_next  = res_freed;
    res_status_next = res_status;
    clr_next        = clr;
    sr_next         = sr;
    pv_next         = pv;
    pidx_next       = pidx;
    out_valid_next  = out_valid;
    out_item_next   = out_item;
    q_ready         = 1'b0;
    bit_we          = 1'b0;
    bit_waddr       = slot;
    bit_wdata       = '0;
    bit_raddr       = slot;
    free_we         = 1'b0;
    free_waddr      = SW'(fc);
    free_raddr      = SW'(fc - 1'b1);
    gray_we         = 1'b0;
    gray_waddr      = SW'(gc);
    gray_raddr      = SW'(gc - 1'b1);

    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      msp_pkg::B_CLEAR: begin
        bit_we    = 1'b1;
        bit_waddr = clr;
        clr_next  = clr + 1'b1;
        if (clr == SW'(SLOTS - 1)) begin
          state_next = msp_pkg::B_IDLE;
          fc_next    = n;
          m_next     = n;
          gc_next    = '0;
        end
      end
      msp_pkg::B_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          cmd_next        = q_cmd;
          slot_next       = q_slot;
          res_addr_next   = '0;
          res_freed_next  = '0;
          res_status_next = msp_pkg::ST_OK;
          state_next      = msp_pkg::B_EXEC;
        end
      end
      msp_pkg::B_EXEC: begin
        case (msp_pkg::action_t'(cmd.action))
          msp_pkg::ACT_ALLOC: begin
            if (fc == '0) begin
              res_status_next = msp_pkg::ST_EMPTY;
              state_next      = msp_pkg::B_RES;
            end else begin
              fc_next = fc - 1'b1;
              if (m == fc) begin
                // entry never pushed since restart: initial fill value
                m_next     = fc - 1'b1;
                slot_next  = SW'(n - fc);
                state_next = msp_pkg::B_BREAD;
              end else begin
                state_next = msp_pkg::B_STACK;
              end
            end
          end
          msp_pkg::ACT_DISCARD, msp_pkg::ACT_MARK: begin
            if (!cmd.hit) begin
              res_status_next = msp_pkg::ST_OUT;
              state_next      = msp_pkg::B_RES;
            end else begin
              state_next = msp_pkg::B_BREAD;
            end
          end
          msp_pkg::ACT_POP_GRAY: begin
            if (gc == '0) begin
              res_status_next = msp_pkg::ST_EMPTY;
              state_next      = msp_pkg::B_RES;
            end else begin
              gc_next    = gc - 1'b1;
              state_next = msp_pkg::B_STACK;
            end
          end
          msp_pkg::ACT_SWEEP: begin
            sr_next    = '0;
            pv_next    = 1'b0;
            state_next = msp_pkg::B_SWEEP;
          end
          default: begin
            res_status_next = msp_pkg::ST_WRONG;
            state_next      = msp_pkg::B_RES;
          end
        endcase
      end
      msp_pkg::B_STACK: begin
        slot_next  = (cmd.action == msp_pkg::ACT_POP_GRAY) ? gray_rdata : free_rdata;
        state_next = msp_pkg::B_BREAD;
      end
      msp_pkg::B_BREAD: begin
        prod_next  = PW'(slot) * PW'(cfg.slot_bytes);
        state_next = msp_pkg::B_BWAIT;
      end
      msp_pkg::B_BWAIT: begin
        state_next = msp_pkg::B_RES;
        case (msp_pkg::action_t'(cmd.action))
          msp_pkg::ACT_ALLOC: begin
            res_addr_next = cfg.pool_base + 32'(prod);
            if (a) begin
              res_status_next = msp_pkg::ST_WRONG;
            end else begin
              bit_we    = 1'b1;
              bit_wdata = {1'b1, rc};
            end
          end
          msp_pkg::ACT_DISCARD: begin
            res_addr_next = cmd.base;
            if (!cmd.aligned || !a) begin
              res_status_next = msp_pkg::ST_WRONG;
            end else begin
              bit_we    = 1'b1;
              bit_wdata = {1'b0, rc};
              if (fc < n) begin
                free_we = 1'b1;
                fc_next = fc + 1'b1;
              end
            end
          end
          msp_pkg::ACT_MARK: begin
            res_addr_next = cmd.base;
            if (!a) begin
              res_status_next = msp_pkg::ST_WRONG;
            end else if (!rc) begin
              bit_we    = 1'b1;
              bit_wdata = 2'b11;
              if (cfg.gray_enable && gc < n) begin
                gray_we = 1'b1;
                gc_next = gc + 1'b1;
              end
            end
          end
          msp_pkg::ACT_POP_GRAY: begin
            res_addr_next = cfg.pool_base + 32'(prod);
            if (!(a && rc)) begin
              res_status_next = msp_pkg::ST_WRONG;
            end
          end
          default: ;
        endcase
      end
      msp_pkg::B_SWEEP: begin
        if (sr < n) begin
          bit_raddr = SW'(sr);
          sr_next   = sr + 1'b1;
          pv_next   = 1'b1;
          pidx_next = SW'(sr);
        end else begin
          pv_next = 1'b0;
        end
        if (pv) begin
          bit_we    = 1'b1;
          bit_waddr = pidx;
          bit_wdata = {a && rc, 1'b0};
          if (a && !rc) begin
            res_freed_next = res_freed + 1'b1;
            if (fc < n) begin
              free_we = 1'b1;
              fc_next = fc + 1'b1;
            end
          end
        end
        if (sr == n && !pv) begin
          state_next = msp_pkg::B_RES;
        end
      end
      msp_pkg::B_RES: begin
        if (!out_valid || out_ready) begin
          out_valid_next               = 1'b1;
          out_item_next.result_address = res_addr;
          out_item_next.freed_count    = msp_pkg::FREED_W'(res_freed);
          out_item_next.status         = res_status;
          state_next                   = msp_pkg::B_IDLE;
        end
      end
      default: state_next = msp_pkg::B_IDLE;
    endcase

    if (restart) begin
      state_next = msp_pkg::B_CLEAR;
      clr_next   = '0;
    end
  end

  // sweep pushes the slot under write, not the held one
  always_comb begin
    free_wdata_sel = (state == msp_pkg::B_SWEEP) ? pidx : slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= msp_pkg::B_CLEAR;
      clr       <= '0;
      out_valid <= 1'b0;
      fc        <= '0;
      m         <= '0;
      gc        <= '0;
      pv        <= 1'b0;
      sr        <= '0;
    end else begin
      state     <= state_next;
      clr       <= clr_next;
      out_valid <= out_valid_next;
      fc        <= fc_next;
      m         <= m_next;
      gc        <= gc_next;
      pv        <= pv_next;
      sr        <= sr_next;
    end
    cmd        <= cmd_next;
    slot       <= slot_next;
    prod       <= prod_next;
    res_addr   <= res_addr_next;
    res_freed  <= res_freed_next;
    res_status <= res_status_next;
    pidx       <= pidx_next;
    out_item   <= out_item_next;
  end

endmodule

// File: tb/mark_sweep_slot_pool_chk.sv
// ----------------------------------------------------------------------------
// mark_sweep_slot_pool_chk
// Watches the item and result channels and the register port, keeps its own
// copy of the pool state, and compares every result beat in order.
// ----------------------------------------------------------------------------
module mark_sweep_slot_pool_chk
  import msp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [3:0] paddr,
  input  logic [31:0] pwdata,
  input  logic       pready,
  input  logic       in_valid,
  input  logic       in_ready,
  input  in_item_t   in_item,
  input  logic       out_valid,
  input  logic       out_ready,
  input  out_item_t  out_item,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NS = SLOTS_DEF;

  logic [31:0] base_r;
  logic [12:0] bytes_r;
  logic [10:0] slots_r;
  logic        gray_en_r;

  bit          alloc_map [NS];
  bit          mark_map  [NS];
  logic [9:0]  free_stk  [NS];
  int          free_n;
  logic [9:0]  gray_stk  [NS];
  int          gray_n;

  out_item_t   want_q[$];

  function automatic int eff_bytes();
    if (bytes_r == 0) return 1;
    if (bytes_r > 4096) return 4096;
    return bytes_r;
  endfunction

  function automatic int eff_slots();
    if (slots_r == 0) return 1;
    if (slots_r > NS) return NS;
    return slots_r;
  endfunction

  function automatic logic [31:0] slot_base(int s);
    logic [63:0] a;
    a = 64'(base_r) + 64'(s) * 64'(eff_bytes());
    return a[31:0];
  endfunction

  task automatic restart_pool();
    int n;
    n = eff_slots();
    for (int i = 0; i < NS; i++) begin
      alloc_map[i] = 0;
      mark_map[i] = 0;
      free_stk[i] = 0;
      gray_stk[i] = 0;
    end
    for (int i = 0; i < n; i++) free_stk[i] = 10'(n - 1 - i);
    free_n = n;
    gray_n = 0;
  endtask

  task automatic push_free(int s);
    if (free_n < eff_slots()) begin
      free_stk[free_n] = 10'(s);
      free_n++;
    end
  endtask

  task automatic predict_pool(in_item_t it);
    out_item_t r;
    logic [31:0] off;
    longint span;
    bit hit, aligned;
    int s, n;
    r = '0;
    n = eff_slots();
    off = it.address - base_r;
    span = longint'(n) * eff_bytes();
    hit = longint'(off) < span;
    s = hit ? int'(off / eff_bytes()) : 0;
    aligned = (off % eff_bytes()) == 0;
    r.status = ST_OK;
    case (it.action)
      ACT_ALLOC: begin
        if (free_n == 0) r.status = ST_EMPTY;
        else begin
          free_n--;
          s = free_stk[free_n];
          r.result_address = slot_base(s);
          if (alloc_map[s]) r.status = ST_WRONG;
          else alloc_map[s] = 1;
        end
      end
      ACT_DISCARD: begin
        if (!hit) r.status = ST_OUT;
        else begin
          r.result_address = slot_base(s);
          if (!aligned || !alloc_map[s]) r.status = ST_WRONG;
          else begin
            alloc_map[s] = 0;
            push_free(s);
          end
        end
      end
      ACT_MARK: begin
        if (!hit) r.status = ST_OUT;
        else begin
          r.result_address = slot_base(s);
          if (!alloc_map[s]) r.status = ST_WRONG;
          else if (!mark_map[s]) begin
            if (gray_en_r && gray_n < n) begin
              gray_stk[gray_n] = 10'(s);
              gray_n++;
            end
            mark_map[s] = 1;
          end
        end
      end
      ACT_POP_GRAY: begin
        if (gray_n == 0) r.status = ST_EMPTY;
        else begin
          gray_n--;
          s = gray_stk[gray_n];
          r.result_address = slot_base(s);
          if (!alloc_map[s] || !mark_map[s]) r.status = ST_WRONG;
        end
      end
      ACT_SWEEP: begin
        for (int i = 0; i < n; i++) begin
          if (alloc_map[i] && !mark_map[i]) begin
            push_free(i);
            r.freed_count++;
          end
          alloc_map[i] = alloc_map[i] & mark_map[i];
          mark_map[i] = 0;
        end
      end
      default: r.status = ST_WRONG;
    endcase
    want_q.push_back(r);
  endtask

  assign pending = want_q.size();

  always @(posedge clk) begin
    out_item_t w;
    if (rst) begin
      base_r = 0;
      bytes_r = BYTES_RESET;
      slots_r = SLOTS_RESET;
      gray_en_r = 1;
      restart_pool();
      want_q = {};
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_t'(paddr[3:2]))
          REG_POOL_BASE:    base_r = pwdata;
          REG_SLOT_BYTES:   bytes_r = pwdata[12:0];
          REG_SLOTS_IN_USE: begin
            slots_r = pwdata[10:0];
            restart_pool();
          end
          REG_GRAY_ENABLE:  gray_en_r = pwdata[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (want_q.size() == 0) begin
          $error("unexpected result beat %h", out_item);
          fail_count++;
        end else begin
          w = want_q.pop_front();
          if (out_item.result_address !== w.result_address) begin
            $error("result_address expected %h actual %h",
                   w.result_address, out_item.result_address);
            fail_count++;
          end
          if (out_item.freed_count !== w.freed_count) begin
            $error("freed_count expected %0d actual %0d",
                   w.freed_count, out_item.freed_count);
            fail_count++;
          end
          if (out_item.status !== w.status) begin
            $error("status expected %0d actual %0d", w.status, out_item.status);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) predict_pool(in_item);
    end
  end
endmodule

// File: tb/mark_sweep_slot_pool_tb.sv
// ----------------------------------------------------------------------------
// mark_sweep_slot_pool_tb
// Drives register phases and action streams into the slot pool, with random
// gaps and receiver stalls; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module mark_sweep_slot_pool_tb;
  import msp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;

  logic        clk = 0;
  logic        rst = 1;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 0;
  out_item_t   out_item;
  int          fail_count, pending;
  int          cycles = 0;
  bit          hold_off = 0;

  logic [31:0] cur_base;
  int          cur_bytes, cur_slots;
  logic [31:0] live_q[$];

  always #4 clk = ~clk;

  mark_sweep_slot_pool i_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready, .in_item, .out_valid, .out_ready, .out_item
  );

  mark_sweep_slot_pool_chk i_chk (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid, .in_ready, .in_item, .out_valid, .out_ready, .out_item,
    .fail_count, .pending
  );

  function automatic int short_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("mark_sweep_slot_pool verification failed");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int g;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 0;
        repeat (3000) @(negedge clk);
        hold_off = 0;
      end
      g = (cycles % 2000 < 400) ? 0 : short_gap();
      if (g > 0) begin
        out_ready <= 0;
        repeat (g - 1) @(negedge clk);
      end else out_ready <= 1;
    end
  end

  task automatic reg_write(reg_t r, logic [31:0] v);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {r, 2'b00}; pwdata <= v;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // valid drops only across a gap, so back-to-back beats keep it high
  task automatic send_raw(logic [2:0] act, logic [31:0] addr);
    int g;
    g = short_gap();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1;
    in_item <= '{action: act, address: addr};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_beat(action_t a, logic [31:0] addr);
    send_raw(a, addr);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (1200) @(negedge clk);
  endtask

  task automatic set_pool(logic [31:0] b, int by, int sl, bit ge);
    drain();
    reg_write(REG_POOL_BASE, b);
    reg_write(REG_SLOT_BYTES, 32'(by));
    reg_write(REG_GRAY_ENABLE, 32'(ge));
    reg_write(REG_SLOTS_IN_USE, 32'(sl));
    repeat (1100) @(negedge clk);
    cur_base = b;
    cur_bytes = (by == 0) ? 1 : (by > 4096 ? 4096 : by);
    cur_slots = (sl == 0) ? 1 : (sl > 1024 ? 1024 : sl);
    live_q = {};
  endtask

  function automatic logic [31:0] pick_addr();
    int k;
    k = $urandom_range(0, 9);
    if (k < 5 && live_q.size() > 0)
      return live_q[$urandom_range(0, live_q.size() - 1)]
             + ((k == 4) ? $urandom_range(0, cur_bytes - 1) : 0);
    if (k < 8)
      return cur_base + $urandom_range(0, cur_slots - 1) * cur_bytes
             + ((k == 7) ? $urandom_range(0, cur_bytes - 1) : 0);
    return $urandom;
  endfunction

  // well-formed collection cycles with random noise mixed in
  task automatic random_phase(int items);
    int k;
    for (int i = 0; i < items; i++) begin
      k = $urandom_range(0, 99);
      if (k < 35) begin
        send_beat(ACT_ALLOC, $urandom);
        if (live_q.size() < 64)
          live_q.push_back(cur_base + live_q.size() * cur_bytes);
      end else if (k < 50) send_beat(ACT_DISCARD, pick_addr());
      else if (k < 72) send_beat(ACT_MARK, pick_addr());
      else if (k < 88) send_beat(ACT_POP_GRAY, $urandom);
      else if (k < 94) send_beat(ACT_SWEEP, $urandom);
      else send_raw(3'($urandom_range(0, 7)), $urandom);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    set_pool(32'h0, 16, 1024, 1);
    // directed: empty pops, unknown codes, every action and edge addresses
    send_beat(ACT_POP_GRAY, 0);
    send_beat(ACT_SWEEP, 0);
    for (int c = 5; c < 8; c++) send_raw(3'(c), 32'hFFFF_FFFF);
    send_beat(ACT_ALLOC, 0);
    send_beat(ACT_ALLOC, 0);
    send_beat(ACT_MARK, 32'h0000_0005);
    send_beat(ACT_MARK, 32'h0000_0000);
    send_beat(ACT_MARK, 32'h0000_0020);
    send_beat(ACT_MARK, 32'hFFFF_FFFF);
    send_beat(ACT_DISCARD, 32'h0000_0011);
    send_beat(ACT_DISCARD, 32'h0000_4000);
    send_beat(ACT_DISCARD, 32'h0000_0020);
    send_beat(ACT_POP_GRAY, 0);
    send_beat(ACT_SWEEP, 0);
    send_beat(ACT_POP_GRAY, 0);
    send_beat(ACT_DISCARD, 32'h0000_0000);
    send_beat(ACT_DISCARD, 32'h0000_0000);
    // tiny pool: exhaust free stack, full gray stack, wrapped base
    set_pool(32'hFFFF_FFF8, 0, 0, 1);
    send_beat(ACT_ALLOC, 0);
    send_beat(ACT_ALLOC, 0);
    send_beat(ACT_MARK, 32'hFFFF_FFF8);
    send_beat(ACT_MARK, 32'hFFFF_FFF8);
    send_beat(ACT_POP_GRAY, 0);
    send_beat(ACT_SWEEP, 0);
    send_beat(ACT_SWEEP, 0);
    // random phases across settings, extremes included
    set_pool($urandom, 4096, 1024, 1);
    hold_off = 1;
    random_phase(120);
    set_pool(32'hFFFF_F000, 8191, 3, 0);
    random_phase(80);
    set_pool($urandom, $urandom_range(1, 64), $urandom_range(1, 20), 1);
    random_phase(150);
    set_pool($urandom, 1, 2047, 1);
    random_phase(100);
    set_pool($urandom, $urandom_range(1, 4096), $urandom_range(1, 12), $urandom_range(0, 1));
    random_phase(200);
    drain();
    if (fail_count == 0) begin
      $display("mark_sweep_slot_pool verification clean");
    end else begin
      $display("mark_sweep_slot_pool verification failed");
    end
    $finish;
  end
endmodule
